/* hw/rtl/ffpa_pkg.sv */
// Package for the first-fit page allocator.
// Holds sizes, request and status codes, the request, response and
// extent types used across the modules, and a saturating 16-bit add.
`default_nettype none
package ffpa_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int NUM_PAGES   = 32768;
  localparam int ADDR_W      = $clog2(MAX_EXTENTS);
  localparam int USED_W      = $clog2(MAX_EXTENTS + 1);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] page_index;
    logic [15:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] alloc_index;
    logic [15:0] free_count;
    logic [15:0] managed_pages;
  } rsp_t;

  typedef struct packed {
    logic [14:0] start;
    logic [15:0] length;
  } extent_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffpa_extent_ram.sv */
// Extent table storage: one write port, one read port, registered read.
// Depends on ffpa_pkg for the extent type and depth.
`default_nettype none
module ffpa_extent_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ffpa_pkg::ADDR_W-1:0] waddr,
  input  wire ffpa_pkg::extent_t         wdata,
  input  wire logic [ffpa_pkg::ADDR_W-1:0] raddr,
  output ffpa_pkg::extent_t              rdata
);
  import ffpa_pkg::*;

  extent_t mem [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/ffpa_core.sv */
// Sequencer of the allocator: walks the extent table one entry at a time.
// Depends on ffpa_pkg and ffpa_extent_ram.
`default_nettype none
module ffpa_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire ffpa_pkg::req_t req,
  output logic                busy,
  output logic                done,
  input  wire logic           take,
  output ffpa_pkg::rsp_t      result
);
  import ffpa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARD  = 4'd1;
  localparam logic [3:0] S_AEV  = 4'd2;
  localparam logic [3:0] S_SHR  = 4'd3;
  localparam logic [3:0] S_SHW  = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FEV  = 4'd6;
  localparam logic [3:0] S_PRD  = 4'd7;
  localparam logic [3:0] S_PEV  = 4'd8;
  localparam logic [3:0] S_URD  = 4'd9;
  localparam logic [3:0] S_UWR  = 4'd10;
  localparam logic [3:0] S_FINS = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]        state;
  logic [1:0]        op;
  logic [15:0]       cnt;
  logic [14:0]       s;
  logic [16:0]       len;
  logic [USED_W-1:0] i, k, pos, used;
  logic [15:0]       free_total, managed_total;
  logic [1:0]        status;
  logic [14:0]       where;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  extent_t             wdata, rdata;

  ffpa_extent_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [16:0] lim, ccnt;
  logic [USED_W-1:0] i_inc;
  logic [17:0] s_end;
  logic [16:0] e_end;

  assign i_inc = i + USED_W'(1);
  assign lim   = 17'(NUM_PAGES) - {2'b0, req.page_index};
  assign s_end = {3'b0, s} + {1'b0, len};
  assign e_end = {2'b0, rdata.start} + {1'b0, rdata.length};

  always_comb begin
    if ({2'b0, req.page_index} >= 17'(NUM_PAGES)) begin
      ccnt = '0;
    end else if ({1'b0, req.page_count} > lim) begin
      ccnt = lim;
    end else begin
      ccnt = {1'b0, req.page_count};
    end
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = i[ADDR_W-1:0];
    wdata = rdata;
    raddr = i[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        we    = start && req.req_type == REQ_ADD && ccnt != '0 && used < USED_W'(MAX_EXTENTS);
        waddr = used[ADDR_W-1:0];
        wdata = '{start: req.page_index, length: ccnt[15:0]};
      end
      S_AEV: begin
        we    = rdata.length > cnt;
        wdata = '{start: rdata.start + cnt[14:0], length: rdata.length - cnt};
      end
      S_SHR: raddr = i_inc[ADDR_W-1:0];
      S_SHW: we = 1'b1;
      S_FEV: begin
        we    = !(s_end == {3'b0, rdata.start}) && !(e_end == {2'b0, s});
        waddr = k[ADDR_W-1:0];
      end
      S_URD: raddr = ADDR_W'(i - USED_W'(1));
      S_UWR: we = 1'b1;
      S_FINS: begin
        we    = 1'b1;
        waddr = pos[ADDR_W-1:0];
        wdata = '{start: s, length: len[15:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      free_total    <= '0;
      managed_total <= '0;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          op     <= req.req_type;
          i      <= '0;
          k      <= '0;
          status <= ST_OK;
          state  <= S_DONE;
          case (req.req_type)
            REQ_ALLOC: begin
              cnt <= req.page_count;
              if (req.page_count == '0) status <= ST_ZERO;
              else if (req.page_count > free_total) status <= ST_NO_FIT;
              else state <= S_ARD;
            end
            REQ_FREE: begin
              cnt <= ccnt[15:0];
              s   <= req.page_index;
              len <= ccnt;
              if (ccnt == '0) status <= ST_ZERO;
              else state <= S_FRD;
            end
            REQ_ADD: begin
              if (ccnt == '0) status <= ST_ZERO;
              else if (used >= USED_W'(MAX_EXTENTS)) status <= ST_FULL;
              else begin
                used          <= used + USED_W'(1);
                free_total    <= sat_add(free_total, ccnt[15:0]);
                managed_total <= sat_add(managed_total, ccnt[15:0]);
              end
            end
            default: ;
          endcase
        end
        S_ARD: begin
          if (i >= used) begin
            status <= ST_NO_FIT;
            state  <= S_DONE;
          end else begin
            state <= S_AEV;
          end
        end
        S_AEV: begin
          if (rdata.length >= cnt) begin
            where      <= rdata.start;
            free_total <= free_total - cnt;
            state      <= (rdata.length > cnt) ? S_DONE : S_SHR;
          end else begin
            i     <= i_inc;
            state <= S_ARD;
          end
        end
        S_SHR: begin
          if (i_inc >= used) begin
            used  <= used - USED_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_SHW;
          end
        end
        S_SHW: begin
          i     <= i_inc;
          state <= S_SHR;
        end
        // Merge pass: fold touching extents, compact the rest to the front.
        S_FRD: begin
          if (i >= used) begin
            if (k >= USED_W'(MAX_EXTENTS)) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end else begin
              i     <= '0;
              state <= S_PRD;
            end
          end else begin
            state <= S_FEV;
          end
        end
        S_FEV: begin
          if (s_end == {3'b0, rdata.start}) begin
            len <= len + {1'b0, rdata.length};
          end else if (e_end == {2'b0, s}) begin
            s   <= rdata.start;
            len <= len + {1'b0, rdata.length};
          end else begin
            k <= k + USED_W'(1);
          end
          i     <= i_inc;
          state <= S_FRD;
        end
        // Find the insertion point in address order.
        S_PRD: begin
          if (i >= k) begin
            pos   <= k;
            i     <= k;
            state <= S_URD;
          end else begin
            state <= S_PEV;
          end
        end
        S_PEV: begin
          if (s_end <= {3'b0, rdata.start}) begin
            pos   <= i;
            i     <= k;
            state <= S_URD;
          end else begin
            i     <= i_inc;
            state <= S_PRD;
          end
        end
        // Open a slot: move entries pos..k-1 up by one, top first.
        S_URD: state <= (i == pos) ? S_FINS : S_UWR;
        S_UWR: begin
          i     <= i - USED_W'(1);
          state <= S_URD;
        end
        S_FINS: begin
          used       <= k + USED_W'(1);
          free_total <= sat_add(free_total, cnt);
          state      <= S_DONE;
        end
        S_DONE: if (take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    result.status        = status;
    result.alloc_index   = (status == ST_OK && op == REQ_ALLOC) ? where : '0;
    result.free_count    = free_total;
    result.managed_pages = managed_total;
  end

endmodule
`default_nettype wire

/* hw/rtl/first_fit_page_allocator.sv */
// First-fit page allocator with coalescing free-extent table.
// Top level: request/response handshakes and the result register; uses ffpa_core.
`default_nettype none
// A user of this block sends one request at a time: allocate (first extent
// in table order long enough), free (merge with touching extents and insert
// in address order) or add a region (append to the table). Each request
// returns one response with a status and the current free and managed page
// totals. The table holds 64 extents in a RAM with one read and one write
// port that is walked one entry at a time, since every entry is a
// registered read followed by a compare. Add requests and requests refused
// up front (zero count, too few free pages) finish without walking the
// table; an allocate scans it and shifts entries down on an exact fit, and
// a free runs a merge pass, a position search and a shift-up over the
// extents in use. req_stall is high while a request is in progress. The
// response register lets the core work on one request while the previous
// response waits to be taken.
module first_fit_page_allocator (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire ffpa_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ffpa_pkg::rsp_t      rsp
);
  import ffpa_pkg::*;

  logic busy, done, take;
  rsp_t result;

  // Take the finished result when the output register is empty or draining.
  assign take      = !rsp_valid || !rsp_stall;
  assign req_stall = busy;

  ffpa_core u_core (
    .clk(clk), .rst(rst),
    .start(req_valid && !busy), .req(req),
    .busy(busy), .done(done), .take(take), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= done;
    end
  end

  // Hold the payload while stalled; load a finished result when the register is empty or draining.
  always_ff @(posedge clk) begin
    if (take && done) begin
      rsp <= result;
    end
  end

endmodule
`default_nettype wire
